// ----- hw/rtl/csv_field_tokenizer_defines.svh -----
// ---------------------------------------------------------------------------
// csv_field_tokenizer assertion macros
// Shared immediate-consequence and next-cycle property forms on clk / rst_n.
// ---------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// same-cycle implication
`define CSVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/csvt_pkg.sv -----
// ---------------------------------------------------------------------------
// csvt_pkg
// Character codes and the per-transfer result record of the CSV tokenizer.
// ---------------------------------------------------------------------------
package csvt_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic              has_result;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              field_end;
    logic              record_end;
    logic              stray;
  } csvt_res_t;

endpackage

// ----- hw/rtl/csvt_parser.sv -----
// ---------------------------------------------------------------------------
// csvt_parser
// Quote-aware field parse state and the result decode for one character.
// ---------------------------------------------------------------------------
module csvt_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  logic [csvt_pkg::BYTE_W-1:0]    in_byte,
  input  logic                           line_end,
  output csvt_pkg::csvt_res_t            res
);

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_BARE   = 3'd1,
    ST_QUOTED = 3'd2,
    ST_QSEEN  = 3'd3,
    ST_AFTER  = 3'd4
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    res       = '0;
    if (line_end) begin
      state_nxt      = ST_START;
      res.has_result = 1'b1;
      res.field_end  = 1'b1;
      res.record_end = 1'b1;
    end else begin
      case (state_r)
        ST_BARE: begin
          if (in_byte == csvt_pkg::CH_COMMA) begin
            state_nxt      = ST_START;
            res.has_result = 1'b1;
            res.field_end  = 1'b1;
          end else begin
            res.has_result = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = in_byte;
          end
        end
        ST_QUOTED: begin
          if (in_byte == csvt_pkg::CH_QUOTE) begin
            state_nxt = ST_QSEEN;
          end else begin
            res.has_result = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = in_byte;
          end
        end
        ST_QSEEN: begin
          if (in_byte == csvt_pkg::CH_QUOTE) begin
            state_nxt      = ST_QUOTED;
            res.has_result = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = in_byte;
          end else if (in_byte == csvt_pkg::CH_COMMA) begin
            state_nxt      = ST_START;
            res.has_result = 1'b1;
            res.field_end  = 1'b1;
          end else begin
            state_nxt      = ST_AFTER;
            res.has_result = 1'b1;
            res.stray      = 1'b1;
          end
        end
        ST_AFTER: begin
          res.has_result = 1'b1;
          if (in_byte == csvt_pkg::CH_COMMA) begin
            state_nxt     = ST_START;
            res.field_end = 1'b1;
          end else begin
            res.stray = 1'b1;
          end
        end
        default: begin
          if (in_byte inside {csvt_pkg::CH_SPACE, csvt_pkg::CH_TAB}) begin
            state_nxt = ST_START;
          end else if (in_byte == csvt_pkg::CH_QUOTE) begin
            state_nxt = ST_QUOTED;
          end else if (in_byte == csvt_pkg::CH_COMMA) begin
            state_nxt      = ST_START;
            res.has_result = 1'b1;
            res.field_end  = 1'b1;
          end else begin
            state_nxt      = ST_BARE;
            res.has_result = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = in_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/csv_field_tokenizer.sv -----
// ---------------------------------------------------------------------------
// csv_field_tokenizer
// Splits a line byte stream into comma-separated, quote-aware fields.
// ---------------------------------------------------------------------------
// Input channel: one transfer per line character, in_tdata[7:0] the byte;
// in_tlast high marks end of line (the byte is then ignored).
// Output channel: at most one transfer per input transfer. out_tdata is the
// field byte (zero unless byte_valid), out_tuser = {stray, field_end,
// byte_valid}, out_tlast = record_end. Skipped blanks, opening and closing
// quotes give no output transfer.
// Path: each input transfer is captured in the input register, then its result
// in the result register together with the parse state update.
// Throughput: one character per clock, sustained while out_tready is high;
// the combinational parse step between the two registers sets this rate.
// Reset: synchronous rst_n clears both valid flags and returns the parse
// state to field start.
// Stall: with out_tready low and a result pending, the result register holds,
// the input register fills, and in_tready drops until the result transfer completes.
// ---------------------------------------------------------------------------
`include "csv_field_tokenizer_defines.svh"

module csv_field_tokenizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [csvt_pkg::BYTE_W-1:0] in_tdata,   // [7:0] in_byte
  input  logic                        in_tlast,   // line_end
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [csvt_pkg::BYTE_W-1:0] out_tdata,  // [7:0] out_byte
  output logic [2:0]                  out_tuser,  // [0] byte_valid [1] field_end [2] stray
  output logic                        out_tlast   // record_end
);

  logic                        s1_valid_r;
  logic [csvt_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        s1_last_r;
  logic                        out_valid_r;
  csvt_pkg::csvt_res_t         res_r;
  csvt_pkg::csvt_res_t         res_nxt;
  logic                        adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  csvt_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (adv),
    .in_byte  (s1_byte_r),
    .line_end (s1_last_r),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= res_nxt.has_result;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.out_byte;
  assign out_tuser  = {res_r.stray, res_r.field_end, res_r.byte_valid};
  assign out_tlast  = res_r.record_end;

  `CSVT_ASSERT_NOW(a_one_kind, out_valid_r, $onehot(out_tuser), "result must carry exactly one kind")
  `CSVT_ASSERT_NOW(a_rec_has_field, out_valid_r && out_tlast, out_tuser[1], "record end without field end")
  `CSVT_ASSERT_NOW(a_byte_zero, out_valid_r && !out_tuser[0], out_tdata == '0, "non-byte result carries data")
  `CSVT_ASSERT_NOW(a_stall_full, !in_tready, s1_valid_r && out_valid_r && !out_tready, "input stalled without cause")
  `CSVT_ASSERT_NEXT(a_eol_result, adv && s1_last_r, out_valid_r && out_tlast, "end of line lost its record end")

endmodule
